FILE: design/sensor_reply_frame_checker_top_defines.svh
// assertion macros for the sensor reply frame checker
// used by sensor_reply_frame_checker_top.sv, needs clk and rst_n in scope
`ifndef SENSOR_REPLY_FRAME_CHECKER_TOP_DEFINES_SVH
`define SENSOR_REPLY_FRAME_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SRFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SRFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/srfc_pkg.sv
// shared types and constants for the sensor reply frame checker
// no dependencies
package srfc_pkg;

    // frame parser phase
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEAD,
        PH_EXT,
        PH_TRAIL
    } phase_t;

    // status codes of the end-of-frame result
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CSUM_BAD = 2'd1,
        ST_FAIL     = 2'd2,
        ST_LEN_OVER = 2'd3
    } status_t;

    // result kind, carried on tuser
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0]  HEADER_BYTE = 8'h3A;
    localparam int          ARG_FAIL_BIT = 15;

    // header byte positions after the sync byte
    localparam logic [2:0] HIDX_CMD    = 3'd1;
    localparam logic [2:0] HIDX_ARG_HI = 3'd2;
    localparam logic [2:0] HIDX_ARG_LO = 3'd3;
    localparam logic [2:0] HIDX_LEN_HI = 3'd4;
    localparam logic [2:0] HIDX_LEN_LO = 3'd5;
    localparam logic [2:0] HIDX_XOR    = 3'd6;

    localparam int TDATA_W = 64;

endpackage

FILE: design/sensor_reply_frame_checker_top.sv
// sensor reply frame checker: the result of an input transaction is registered onto m_*
// 1 byte/cycle unless a result waits on m_tready; output register refills while taken
// frame state advances with one running xor/sum accumulator pair and a byte counter
// rst_n is asynchronous active low: parser goes to header hunt, expected_command to 0,
// output register empty
// depends on srfc_pkg and sensor_reply_frame_checker_top_defines.svh
`include "sensor_reply_frame_checker_top_defines.svh"

module sensor_reply_frame_checker_top #(
    parameter int MAX_EXT_LEN = 248
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: expected_command
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] data_index, [17:16] status, [25:18] command,
    // [41:26] argument, [57:42] ext_length, [63:58] zero
    output logic [srfc_pkg::TDATA_W-1:0] m_tdata,
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast    // last
);
    import srfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_EXT_LEN + 1);
    localparam logic [15:0] MAX_LEN16 = 16'(MAX_EXT_LEN);

    // state
    phase_t       phase_reg, phase_next;
    logic [2:0]   hidx_reg, hidx_next;
    logic [7:0]   xor_acc_reg, xor_acc_next;
    logic [7:0]   sum_acc_reg, sum_acc_next;
    logic [7:0]   cmd_reg, cmd_next;
    logic [15:0]  arg_reg, arg_next;
    logic [15:0]  len_reg, len_next;
    logic [CNT_W-1:0] ext_count_reg, ext_count_next;
    logic [7:0]   exp_cmd_reg;

    // result register
    logic         m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0] m_data_reg, m_data_next;
    logic         m_kind_reg, m_kind_next;

    logic         in_acc;
    logic [7:0]   b;
    logic         res_valid;
    logic         res_kind;
    logic [7:0]   res_byte;
    logic [7:0]   res_index;
    status_t      res_status;
    logic [7:0]   res_cmd;
    logic [15:0]  res_arg;
    logic [15:0]  res_len;
    logic [15:0]  len_full;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]  count16;

    assign b        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign len_full = {len_reg[15:8], b};
    assign cnt_inc  = ext_count_reg + CNT_W'(1);
    assign count16  = 16'(ext_count_reg);

    // next frame state
    always_comb
    begin
        phase_next     = phase_reg;
        hidx_next      = hidx_reg;
        xor_acc_next   = xor_acc_reg;
        sum_acc_next   = sum_acc_reg;
        cmd_next       = cmd_reg;
        arg_next       = arg_reg;
        len_next       = len_reg;
        ext_count_next = ext_count_reg;
        if (in_acc)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (b == HEADER_BYTE)
                    begin
                        phase_next   = PH_HEAD;
                        hidx_next    = HIDX_CMD;
                        xor_acc_next = b;
                        sum_acc_next = b;
                    end
                end
                PH_HEAD:
                begin
                    sum_acc_next = sum_acc_reg + b;
                    if (hidx_reg == HIDX_XOR)
                    begin
                        if (b != xor_acc_reg)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else if (len_reg == 16'd0)
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else
                        begin
                            phase_next = PH_EXT;
                        end
                    end
                    else
                    begin
                        xor_acc_next = xor_acc_reg ^ b;
                        hidx_next    = hidx_reg + 3'd1;
                        case (hidx_reg)
                            HIDX_CMD:    cmd_next = b;
                            HIDX_ARG_HI: arg_next = {b, 8'h00};
                            HIDX_ARG_LO: arg_next = {arg_reg[15:8], b};
                            HIDX_LEN_HI: len_next = {b, 8'h00};
                            default:
                            begin
                                len_next = len_full;
                                if (len_full > MAX_LEN16)
                                begin
                                    phase_next = PH_HUNT;
                                end
                            end
                        endcase
                    end
                end
                PH_EXT:
                begin
                    sum_acc_next   = sum_acc_reg + b;
                    ext_count_next = cnt_inc;
                    if (16'(cnt_inc) >= len_reg)
                    begin
                        phase_next = PH_TRAIL;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
            // end of frame clears everything
            if (phase_reg != PH_HUNT && phase_next == PH_HUNT)
            begin
                hidx_next      = 3'd0;
                xor_acc_next   = 8'h00;
                sum_acc_next   = 8'h00;
                cmd_next       = 8'h00;
                arg_next       = 16'h0000;
                len_next       = 16'h0000;
                ext_count_next = '0;
            end
        end
    end

    // result formation
    always_comb
    begin
        res_valid  = 1'b0;
        res_kind   = KIND_STATUS;
        res_byte   = 8'h00;
        res_index  = 8'h00;
        res_status = ST_OK;
        res_cmd    = cmd_reg;
        res_arg    = arg_reg;
        res_len    = len_reg;
        case (phase_reg)
            PH_HEAD:
            begin
                if (hidx_reg == HIDX_XOR)
                begin
                    if (b != xor_acc_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_CSUM_BAD;
                    end
                end
                else if (hidx_reg == HIDX_LEN_LO && len_full > MAX_LEN16)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_LEN_OVER;
                    res_len    = len_full;
                end
            end
            PH_EXT:
            begin
                res_valid = 1'b1;
                res_kind  = KIND_DATA;
                res_byte  = b;
                res_index = count16[7:0];
            end
            PH_TRAIL:
            begin
                res_valid = 1'b1;
                if (b != ~sum_acc_reg)
                begin
                    res_status = ST_CSUM_BAD;
                end
                else if (cmd_reg != exp_cmd_reg || arg_reg[ARG_FAIL_BIT])
                begin
                    res_status = ST_FAIL;
                end
                else
                begin
                    res_status = ST_OK;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // output register control
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        if (in_acc && res_valid)
        begin
            m_valid_next = 1'b1;
            m_kind_next  = res_kind;
            m_data_next  = {6'b0, res_len, res_arg, res_cmd, res_status, res_index, res_byte};
        end
    end

    // control and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            hidx_reg      <= 3'd0;
            xor_acc_reg   <= 8'h00;
            sum_acc_reg   <= 8'h00;
            cmd_reg       <= 8'h00;
            arg_reg       <= 16'h0000;
            len_reg       <= 16'h0000;
            ext_count_reg <= '0;
            exp_cmd_reg   <= 8'h00;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hidx_reg      <= hidx_next;
            xor_acc_reg   <= xor_acc_next;
            sum_acc_reg   <= sum_acc_next;
            cmd_reg       <= cmd_next;
            arg_reg       <= arg_next;
            len_reg       <= len_next;
            ext_count_reg <= ext_count_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we)
            begin
                exp_cmd_reg <= cfg_wdata;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_kind_reg;

    // checks
    `SRFC_ASSERT_NOW(a_hunt_clean, phase_reg == PH_HUNT,
        xor_acc_reg == 8'h00 && sum_acc_reg == 8'h00 && len_reg == 16'h0000,
        "frame state not cleared while hunting")
    `SRFC_ASSERT_NOW(a_ext_in_range, phase_reg == PH_EXT,
        count16 < len_reg, "extension count reached frame length in ext phase")
    `SRFC_ASSERT_NEXT(a_hunt_no_result, in_acc && phase_reg == PH_HUNT,
        m_valid_reg == $past(m_valid_reg && !m_tready), "result produced while hunting")

endmodule
